[src/nps_pkg.sv]
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants of the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] task_tag;
    logic [2:0] urgency;
    logic [7:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  running_tag;
    logic [2:0]  running_level;
    logic [15:0] start_time;
    logic [15:0] end_time;
    logic [15:0] now;
  } out_item_t;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [2:0] KIND_ACCEPTED = 3'd0;
  localparam logic [2:0] KIND_DROPPED  = 3'd1;
  localparam logic [2:0] KIND_IDLE     = 3'd2;
  localparam logic [2:0] KIND_RUNNING  = 3'd3;
  localparam logic [2:0] KIND_FINISH   = 3'd4;

  localparam logic [15:0] CUTOFF_RESET = 16'd100;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } sched_state_t;

endpackage

[src/nps_ram.sv]
// ----------------------------------------------------------------------------
// nps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/nonpreemptive_priority_scheduler.sv]
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// Highest-priority-first task scheduler without preemption.
// ----------------------------------------------------------------------------
// Tasks wait in one FIFO per urgency level, all held in a single RAM. Each
// tick runs the active task, else starts the head of the non-empty queue with
// the lowest urgency value before the cutoff time, else reports idle. Arrivals
// and ticks that need no queue read complete in ST_IDLE; a tick that starts a
// new task also passes through ST_FETCH, because the queue head comes out of
// the RAM read port in the cycle after its address is presented. One transaction
// is processed at a time. A spare result register lets the next transaction
// enter while one waits; input stalls in ST_FETCH and while the spare is full.
module nonpreemptive_priority_scheduler
  import nps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int LEVELS      = 4,
  parameter int TIME_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int Q_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ENTRIES = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int CMP_W  = (TIME_BITS > 16) ? TIME_BITS : 16;

  sched_state_t           state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;
  logic                   spare_valid_r, spare_valid_nxt;
  out_item_t              spare_data_r, spare_data_nxt;
  logic                   res_valid;
  out_item_t              res_data;
  logic [TIME_BITS-1:0]   time_r, time_nxt;
  logic [15:0]            cutoff_r;
  logic [PTR_W-1:0]       heads_r [LEVELS];
  logic [PTR_W-1:0]       heads_nxt [LEVELS];
  logic [CNT_W-1:0]       counts_r [LEVELS];
  logic [CNT_W-1:0]       counts_nxt [LEVELS];
  logic                   act_valid_r, act_valid_nxt;
  logic [7:0]             act_tag_r, act_tag_nxt;
  logic [2:0]             act_level_r, act_level_nxt;
  logic [7:0]             act_elapsed_r, act_elapsed_nxt;
  logic [7:0]             act_need_r, act_need_nxt;
  logic [TIME_BITS-1:0]   act_start_r, act_start_nxt;
  logic [Q_W-1:0]         fetch_q_r, fetch_q_nxt;

  logic                   accept;
  logic                   past_cutoff;
  logic                   any_ne;
  logic [Q_W-1:0]         pick_q;
  logic [Q_W-1:0]         urg_q;
  logic [Q_W-1:0]         sel_q;
  logic                   bad_urgency;
  logic                   queue_full;
  logic [PTR_W-1:0]       head_sel;
  logic [CNT_W-1:0]       count_sel;
  logic [SUM_W-1:0]       tail_sum;
  logic [PTR_W-1:0]       tail_pos;
  logic [PTR_W-1:0]       slot;
  logic [ADDR_W-1:0]      ram_addr;
  logic                   ram_wr_en;
  logic                   ram_rd_en;
  logic [15:0]            ram_rd_data;
  logic [CMP_W-1:0]       time_ext;
  logic [CMP_W-1:0]       start_ext;
  logic [7:0]             elapsed_inc;
  logic [7:0]             fetch_need;

  assign in_ready  = (state_r == ST_IDLE) && !spare_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign time_ext    = CMP_W'(time_r);
  assign start_ext   = CMP_W'(act_start_r);
  assign past_cutoff = time_ext >= CMP_W'(cutoff_r);

  always_comb begin
    any_ne = 1'b0;
    pick_q = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (counts_r[i] != '0) begin
        any_ne = 1'b1;
        pick_q = Q_W'(i);
      end
    end
  end

  assign urg_q       = Q_W'(in_data.urgency - 3'd1);
  assign bad_urgency = (in_data.urgency == 3'd0) || ({1'b0, in_data.urgency} > 4'(LEVELS));
  assign sel_q       = (in_data.op == OP_TICK) ? pick_q : urg_q;
  assign head_sel    = heads_r[sel_q];
  assign count_sel   = counts_r[sel_q];
  assign queue_full  = count_sel >= CNT_W'(QUEUE_DEPTH);
  assign tail_sum    = SUM_W'(head_sel) + SUM_W'(count_sel);
  assign tail_pos    = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                       PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign slot        = (in_data.op == OP_TICK) ? head_sel : tail_pos;
  assign ram_addr    = ADDR_W'(sel_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);

  assign elapsed_inc = act_elapsed_r + 8'd1;
  assign fetch_need  = ram_rd_data[7:0];

  always_comb begin
    state_nxt       = state_r;
    res_valid       = 1'b0;
    res_data        = '0;
    time_nxt        = time_r;
    heads_nxt       = heads_r;
    counts_nxt      = counts_r;
    act_valid_nxt   = act_valid_r;
    act_tag_nxt     = act_tag_r;
    act_level_nxt   = act_level_r;
    act_elapsed_nxt = act_elapsed_r;
    act_need_nxt    = act_need_r;
    act_start_nxt   = act_start_r;
    fetch_q_nxt     = fetch_q_r;
    ram_wr_en       = 1'b0;
    ram_rd_en       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_data     = '0;
          res_data.now = time_ext[15:0];
          if (in_data.op == OP_ARRIVAL) begin
            res_valid = 1'b1;
            if (bad_urgency || past_cutoff || queue_full) begin
              res_data.kind = KIND_DROPPED;
            end else begin
              ram_wr_en         = 1'b1;
              counts_nxt[sel_q] = count_sel + CNT_W'(1);
              res_data.kind     = KIND_ACCEPTED;
            end
          end else if (act_valid_r) begin
            res_valid              = 1'b1;
            act_elapsed_nxt        = elapsed_inc;
            res_data.running_tag   = act_tag_r;
            res_data.running_level = act_level_r;
            res_data.start_time    = start_ext[15:0];
            if (elapsed_inc >= act_need_r) begin
              res_data.kind     = KIND_FINISH;
              res_data.end_time = time_ext[15:0];
              act_valid_nxt     = 1'b0;
            end else begin
              res_data.kind = KIND_RUNNING;
            end
            if (time_r != {TIME_BITS{1'b1}}) begin
              time_nxt = time_r + TIME_BITS'(1);
            end
          end else if (past_cutoff || !any_ne) begin
            res_valid     = 1'b1;
            res_data.kind = KIND_IDLE;
            if (past_cutoff) begin
              for (int i = 0; i < LEVELS; i++) begin
                heads_nxt[i]  = '0;
                counts_nxt[i] = '0;
              end
            end
            if (time_r != {TIME_BITS{1'b1}}) begin
              time_nxt = time_r + TIME_BITS'(1);
            end
          end else begin
            ram_rd_en         = 1'b1;
            fetch_q_nxt       = pick_q;
            heads_nxt[sel_q]  = (head_sel == PTR_W'(QUEUE_DEPTH - 1)) ?
                                '0 : head_sel + PTR_W'(1);
            counts_nxt[sel_q] = count_sel - CNT_W'(1);
            state_nxt         = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        res_valid              = 1'b1;
        act_tag_nxt            = ram_rd_data[15:8];
        act_need_nxt           = fetch_need;
        act_level_nxt          = 3'(fetch_q_r) + 3'd1;
        act_elapsed_nxt        = 8'd1;
        act_start_nxt          = time_r;
        res_data               = '0;
        res_data.now           = time_ext[15:0];
        res_data.running_tag   = ram_rd_data[15:8];
        res_data.running_level = 3'(fetch_q_r) + 3'd1;
        res_data.start_time    = time_ext[15:0];
        if (fetch_need <= 8'd1) begin
          res_data.kind     = KIND_FINISH;
          res_data.end_time = time_ext[15:0];
          act_valid_nxt     = 1'b0;
        end else begin
          res_data.kind = KIND_RUNNING;
          act_valid_nxt = 1'b1;
        end
        if (time_r != {TIME_BITS{1'b1}}) begin
          time_nxt = time_r + TIME_BITS'(1);
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    spare_valid_nxt = spare_valid_r;
    spare_data_nxt  = spare_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt   = spare_valid_r;
      out_data_nxt    = spare_data_r;
      spare_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_data;
      end else begin
        spare_valid_nxt = 1'b1;
        spare_data_nxt  = res_data;
      end
    end
  end

  nps_ram #(
    .WIDTH(16),
    .DEPTH(ENTRIES)
  ) u_queue_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_addr),
    .wr_data({in_data.task_tag, in_data.run_length}),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_addr),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
      time_r        <= '0;
      cutoff_r      <= CUTOFF_RESET;
      act_valid_r   <= 1'b0;
      act_tag_r     <= '0;
      act_level_r   <= '0;
      act_elapsed_r <= '0;
      act_need_r    <= '0;
      act_start_r   <= '0;
      fetch_q_r     <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        heads_r[i]  <= '0;
        counts_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      spare_valid_r <= spare_valid_nxt;
      time_r        <= time_nxt;
      act_valid_r   <= act_valid_nxt;
      act_tag_r     <= act_tag_nxt;
      act_level_r   <= act_level_nxt;
      act_elapsed_r <= act_elapsed_nxt;
      act_need_r    <= act_need_nxt;
      act_start_r   <= act_start_nxt;
      fetch_q_r     <= fetch_q_nxt;
      heads_r       <= heads_nxt;
      counts_r      <= counts_nxt;
      if (cfg_wr_en) begin
        cutoff_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    spare_data_r <= spare_data_nxt;
  end

endmodule
